/* hw/rtl/length_prefixed_message_ring_core_assert.svh */
// Assertion macros for the message ring core.
`ifndef LENGTH_PREFIXED_MESSAGE_RING_CORE_ASSERT_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_CORE_ASSERT_SVH
// Assert that a condition implies a consequence on the same edge.
`define LPMR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence on the next edge.
`define LPMR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/lpmr_pkg.sv */
// Package with payload types and codes for the message ring core.
`default_nettype none
package lpmr_pkg;
    localparam int LEN_W = 13;

    localparam logic [1:0] KIND_WR_HDR  = 2'd0;
    localparam logic [1:0] KIND_WR_DATA = 2'd1;
    localparam logic [1:0] KIND_RD_HDR  = 2'd2;
    localparam logic [1:0] KIND_RD_DATA = 2'd3;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_FULL  = 3'd1;
    localparam logic [2:0] ST_EMPTY = 3'd2;
    localparam logic [2:0] ST_SMALL = 3'd3;
    localparam logic [2:0] ST_SEQ   = 3'd4;

    typedef struct packed {
        logic [1:0]       kind;
        logic [LEN_W-1:0] msg_len;
        logic [7:0]       data_in;
        logic [LEN_W-1:0] capacity;
    } t_in_item;

    typedef struct packed {
        logic [2:0]       status;
        logic [LEN_W-1:0] length;
        logic [7:0]       data_out;
        logic             last;
    } t_out_item;
endpackage
`default_nettype wire

/* hw/rtl/lpmr_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module lpmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

/* hw/rtl/lpmr_queue.sv */
// Two-entry queue between the front and back parts.
`default_nettype none
module lpmr_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_flush,
    input  wire logic              i_push,
    input  lpmr_pkg::t_in_item     i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output lpmr_pkg::t_in_item     o_data
);
    import lpmr_pkg::*;

    t_in_item   r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/lpmr_back.sv */
// Back part: executes ring items against the byte store.
`default_nettype none
module lpmr_back #(
    parameter int DEPTH        = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [lpmr_pkg::LEN_W-1:0] i_cfg_wdata,
    input  wire logic                    i_valid,
    input  lpmr_pkg::t_in_item           i_item,
    output logic                         o_pop,
    output logic                         o_valid,
    output lpmr_pkg::t_out_item          o_item,
    input  wire logic                    i_stall
);
    import lpmr_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = AW + 1;
    localparam int HW = $clog2(HEADER_BYTES + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WHDR = 3'd1;
    localparam logic [2:0] S_RHDR = 3'd2;
    localparam logic [2:0] S_RDAT = 3'd3;
    localparam logic [2:0] S_RWAIT = 3'd4;
    localparam logic [2:0] S_HWAIT = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [SW-1:0]    r_size;
    logic [AW-1:0]    r_wpos, r_cpos, r_rpos, r_hpos;
    logic [LEN_W-1:0] r_wrem, r_rrem;
    logic [HW-1:0]    r_hcnt;
    logic [63:0]      r_hval;
    logic             r_ovalid;
    t_out_item        r_out;

    logic             ram_we;
    logic [AW-1:0]    ram_addr;
    logic [7:0]       ram_wdata, ram_rdata;
    logic [SW-1:0]    used, free_b, size_eff;
    logic [LEN_W+1:0] need;
    logic             out_free, hdr_fits;
    logic [12:0]      cfg_clamp;

    lpmr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] p, input logic [SW-1:0] s);
        logic [SW-1:0] n;
        n = {1'b0, p} + SW'(1);
        return (n >= s) ? '0 : n[AW-1:0];
    endfunction

    assign size_eff = r_size;
    assign used = ({1'b0, r_cpos} >= {1'b0, r_rpos})
                ? ({1'b0, r_cpos} - {1'b0, r_rpos})
                : ({1'b0, r_cpos} + size_eff - {1'b0, r_rpos});
    assign free_b = size_eff - used;
    assign need   = {2'b0, i_item.msg_len} + (LEN_W+2)'(HEADER_BYTES);
    assign hdr_fits = (HEADER_BYTES >= 2) ? 1'b1
                    : (i_item.msg_len[LEN_W-1:8] == '0);
    assign out_free = !r_ovalid || !i_stall;
    assign o_valid  = r_ovalid;
    assign o_item   = r_out;

    // Clamp ring size into [16, DEPTH].
    always_comb begin
        cfg_clamp = i_cfg_wdata;
        if (32'(i_cfg_wdata) < 16) begin
            cfg_clamp = 13'd16;
        end else if (32'(i_cfg_wdata) > DEPTH) begin
            cfg_clamp = 13'(DEPTH);
        end
    end

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_rpos;
        ram_wdata = i_item.data_in;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && out_free) begin
                    unique case (i_item.kind)
                        KIND_WR_HDR: begin
                            if (r_wrem == '0
                                && !({{(SW > LEN_W+2 ? 0 : LEN_W+2-SW){1'b0}}, free_b}
                                     <= need[LEN_W+1:0]) && hdr_fits) begin
                                n_state = S_WHDR;
                            end else begin
                                o_pop = 1'b1;
                            end
                        end
                        KIND_WR_DATA: begin
                            o_pop = 1'b1;
                            if (r_wrem != '0) begin
                                ram_we   = 1'b1;
                                ram_addr = r_wpos;
                            end
                        end
                        KIND_RD_HDR: begin
                            if (r_rrem == '0 && r_rpos != r_cpos) begin
                                n_state = S_RHDR;
                            end else begin
                                o_pop = 1'b1;
                            end
                        end
                        KIND_RD_DATA: begin
                            if (r_rrem != '0) begin
                                n_state = S_RDAT;
                            end else begin
                                o_pop = 1'b1;
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            S_WHDR: begin
                ram_we    = 1'b1;
                ram_addr  = r_hpos;
                ram_wdata = r_hval[8*r_hcnt +: 8];
                if (32'(r_hcnt) == HEADER_BYTES - 1) begin
                    o_pop   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RHDR: begin
                ram_addr = r_hpos;
                n_state  = (32'(r_hcnt) == HEADER_BYTES - 1) ? S_HWAIT : S_RHDR;
            end
            S_HWAIT: begin
                // Hold the item until the last header byte is in.
                o_pop   = out_free && (r_hcnt == '0);
                n_state = (out_free && (r_hcnt == '0)) ? S_IDLE : S_HWAIT;
            end
            S_RDAT: begin
                ram_addr = r_rpos;
                n_state  = S_RWAIT;
            end
            S_RWAIT: begin
                o_pop   = out_free;
                n_state = out_free ? S_IDLE : S_RWAIT;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= SW'(DEPTH);
            r_wpos   <= '0;
            r_cpos   <= '0;
            r_rpos   <= '0;
            r_wrem   <= '0;
            r_rrem   <= '0;
            r_ovalid <= 1'b0;
            r_hcnt   <= '0;
        end else if (i_cfg_we) begin
            r_state  <= S_IDLE;
            r_size   <= SW'(cfg_clamp);
            r_wpos   <= '0;
            r_cpos   <= '0;
            r_rpos   <= '0;
            r_wrem   <= '0;
            r_rrem   <= '0;
            r_ovalid <= 1'b0;
            r_hcnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_hcnt <= '0;
                    r_hpos <= (i_item.kind == KIND_WR_HDR) ? r_wpos : r_rpos;
                    r_hval <= 64'(i_item.msg_len);
                    if (i_valid && out_free) begin
                        r_out <= '0;
                        if (o_pop) begin
                            r_ovalid <= 1'b1;
                        end
                        unique case (i_item.kind)
                            KIND_WR_HDR: begin
                                if (r_wrem != '0) begin
                                    r_out.status <= ST_SEQ;
                                end else if (o_pop) begin
                                    r_out.status <= ST_FULL;
                                end
                            end
                            KIND_WR_DATA: begin
                                if (r_wrem == '0) begin
                                    r_out.status <= ST_SEQ;
                                end else begin
                                    r_wpos <= adv(r_wpos, r_size);
                                    r_wrem <= r_wrem - 1'b1;
                                    if (r_wrem == LEN_W'(1)) begin
                                        r_cpos <= adv(r_wpos, r_size);
                                    end
                                end
                            end
                            KIND_RD_HDR: begin
                                if (r_rrem != '0) begin
                                    r_out.status <= ST_SEQ;
                                end else if (r_rpos == r_cpos) begin
                                    r_out.status <= ST_EMPTY;
                                end
                            end
                            KIND_RD_DATA: begin
                                if (r_rrem == '0) begin
                                    r_out.status <= ST_SEQ;
                                end
                            end
                            default: r_out.status <= ST_SEQ;
                        endcase
                    end
                end
                S_WHDR: begin
                    r_hcnt <= r_hcnt + 1'b1;
                    r_hpos <= adv(r_hpos, r_size);
                    if (32'(r_hcnt) == HEADER_BYTES - 1) begin
                        r_wpos   <= adv(r_hpos, r_size);
                        r_wrem   <= i_item.msg_len;
                        r_ovalid <= 1'b1;
                        r_out    <= '0;
                        if (i_item.msg_len == '0) begin
                            r_cpos <= adv(r_hpos, r_size);
                        end
                    end
                end
                S_RHDR: begin
                    // Read data arrives in the cycle after its address; collect it here.
                    r_hpos <= adv(r_hpos, r_size);
                    r_hcnt <= r_hcnt + 1'b1;
                    if (r_hcnt == '0) begin
                        r_hval <= '0;
                    end else begin
                        r_hval[8*(r_hcnt-1'b1) +: 8] <= ram_rdata;
                    end
                end
                S_HWAIT: begin
                    if (r_hcnt != '0) begin
                        r_hval[8*(r_hcnt-1'b1) +: 8] <= ram_rdata;
                        r_hcnt <= '0;
                    end else if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_out    <= '0;
                        if (64'(i_item.capacity) < r_hval) begin
                            r_out.status <= ST_SMALL;
                        end else begin
                            r_rpos <= r_hpos;
                            r_rrem <= r_hval[LEN_W-1:0];
                            r_out.length <= r_hval[LEN_W-1:0];
                        end
                    end
                end
                S_RDAT: begin
                end
                S_RWAIT: begin
                    if (out_free) begin
                        r_ovalid       <= 1'b1;
                        r_out          <= '0;
                        r_out.data_out <= ram_rdata;
                        r_out.last     <= (r_rrem == LEN_W'(1));
                        r_rpos         <= adv(r_rpos, r_size);
                        r_rrem         <= r_rrem - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/length_prefixed_message_ring_core.sv */
// Top level of the length-prefixed message ring.
// Results are registered. Write data and rejected items answer from S_IDLE; read
// data passes S_RDAT, S_RWAIT; headers walk the single-port byte store byte by
// byte, eight by default (S_WHDR, or S_RHDR then S_HWAIT). Write data: one per
// cycle unless the output stalls; the next read data item waits for S_RWAIT.
// Reset: synchronous, active low; positions and counts clear, ring size is DEPTH (default 4096).
`default_nettype none
`include "length_prefixed_message_ring_core_assert.svh"
module length_prefixed_message_ring_core #(
    parameter int DEPTH        = 4096,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [lpmr_pkg::LEN_W-1:0] i_cfg_wdata,
    input  wire logic                       i_valid,
    input  lpmr_pkg::t_in_item              i_item,
    output logic                            o_stall,
    output logic                            o_valid,
    output lpmr_pkg::t_out_item             o_item,
    input  wire logic                       i_stall
);
    import lpmr_pkg::*;

    logic     q_full, q_valid, q_pop, in_xfer;
    t_in_item q_item;

    // Front: take items into the queue.
    assign o_stall = q_full;
    assign in_xfer = i_valid && !q_full;

    lpmr_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_flush(i_cfg_we),
        .i_push (in_xfer),
        .i_data (i_item),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_item)
    );

    lpmr_back #(.DEPTH(DEPTH), .HEADER_BYTES(HEADER_BYTES)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_valid    (o_valid),
        .o_item     (o_item),
        .i_stall    (i_stall)
    );

    `LPMR_ASSERT_IMPL(a_pop_needs_item, i_clk, i_rst_n, q_pop, q_valid)
    `LPMR_ASSERT_IMPL(a_last_is_ok, i_clk, i_rst_n, o_valid && o_item.last,
        o_item.status == ST_OK)
    `LPMR_ASSERT_NEXT(a_cfg_clears_out, i_clk, i_rst_n, i_cfg_we, !o_valid)
endmodule
`default_nettype wire
